[rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the ARP cache with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int AGE_W           = 8;
    localparam int CMD_W           = 2;
    localparam int DEFAULT_ENTRIES = 64;

    localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(15);

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/arpc_if.sv]
// ----------------------------------------------------------------------------
// arpc_if
// Valid/ready channels of the ARP cache: requests, responses, timeout writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_req_if;
    logic                         valid;
    logic                         ready;
    logic [arpc_pkg::CMD_W-1:0]   cmd;
    logic [arpc_pkg::IP_W-1:0]    ip_address;
    logic [arpc_pkg::MAC_W-1:0]   mac_address;

    modport source (output valid, cmd, ip_address, mac_address, input ready);
    modport sink   (input valid, cmd, ip_address, mac_address, output ready);
endinterface

interface arpc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [arpc_pkg::MAC_W-1:0]   hit_mac;
    logic                         stored;

    modport source (output valid, hit, hit_mac, stored, input ready);
    modport sink   (input valid, hit, hit_mac, stored, output ready);
endinterface

interface arpc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [arpc_pkg::AGE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/arpc_ram.sv]
// ----------------------------------------------------------------------------
// arpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/arp_cache_with_aging_unit.sv]
// ----------------------------------------------------------------------------
// arp_cache_with_aging_unit
// IP-to-MAC cache with lookup, insert and aging tick over a RAM-held table.
// ----------------------------------------------------------------------------
// Every entry (valid, age, IP, MAC) sits in one word of a single-port-read
// RAM. After reset the block writes every entry invalid and accepts no
// request meanwhile; timeout writes are taken at any time. A lookup or a
// tick walks all entries, one RAM read per cycle; a tick writes each valid
// entry back the cycle after reading it. An insert stops at the lowest free
// slot. Unused command code 3 returns an all-zero response. One request is
// in work at a time; the response register lets the next request enter
// while the previous response still waits.
`default_nettype none

module arp_cache_with_aging_unit #(
    parameter int TABLE_ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    arpc_req_if.sink    req,
    arpc_rsp_if.source  rsp,
    arpc_cfg_if.sink    cfg
);

    import arpc_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] N_C  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              dvalid_reg, dvalid_next;
    logic [AW-1:0]     dat_idx_reg, dat_idx_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [AGE_W-1:0]  timeout_reg;
    logic              res_hit_reg, res_hit_next;
    logic [MAC_W-1:0]  res_mac_reg, res_mac_next;
    logic              res_stored_reg, res_stored_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;
    logic [MAC_W-1:0]  out_mac_reg;
    logic              out_stored_reg;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    entry_t            ram_wdata, rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              req_take;
    logic              out_load;
    logic              scan_done;
    logic              last_data;
    logic [AGE_W-1:0]  age_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid   = out_valid_reg;
    assign rsp.hit     = out_hit_reg;
    assign rsp.hit_mac = out_mac_reg;
    assign rsp.stored  = out_stored_reg;

    assign rd_entry  = entry_t'(ram_rdata);
    assign last_data = (CW'(dat_idx_reg) == LAST);
    assign age_inc   = (rd_entry.age == AGE_MAX) ? AGE_MAX : rd_entry.age + AGE_W'(1);

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (rd_idx_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (req.cmd == CMD_NONE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Table walk, write-back and response
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = dat_idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[AW-1:0];
        rd_idx_next     = rd_idx_reg;
        dvalid_next     = 1'b0;
        dat_idx_next    = rd_idx_reg[AW-1:0];
        res_hit_next    = res_hit_reg;
        res_mac_next    = res_mac_reg;
        res_stored_next = res_stored_reg;
        scan_done       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = rd_idx_reg[AW-1:0];
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    rd_idx_next     = '0;
                    res_hit_next    = 1'b0;
                    res_mac_next    = '0;
                    res_stored_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < N_C)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                    dvalid_next = 1'b1;
                end
                if (dvalid_reg)
                begin
                    scan_done = last_data;
                    case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            // later matches override: highest index wins
                            if (rd_entry.valid && rd_entry.ip == ip_reg)
                            begin
                                res_hit_next = 1'b1;
                                res_mac_next = rd_entry.mac;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (!rd_entry.valid)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata.valid = 1'b1;
                                ram_wdata.age   = '0;
                                ram_wdata.ip    = ip_reg;
                                ram_wdata.mac   = mac_reg;
                                res_stored_next = 1'b1;
                                scan_done       = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (rd_entry.valid)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = rd_entry;
                                ram_wdata.age   = age_inc;
                                ram_wdata.valid = (age_inc <= timeout_reg);
                            end
                        end
                        default:
                        begin
                            scan_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            rd_idx_reg     <= '0;
            dvalid_reg     <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
            res_hit_reg    <= 1'b0;
            res_stored_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            dvalid_reg     <= dvalid_next;
            res_hit_reg    <= res_hit_next;
            res_stored_reg <= res_stored_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dat_idx_reg <= dat_idx_next;
        res_mac_reg <= res_mac_next;
        if (req_take)
        begin
            cmd_reg <= req.cmd;
            ip_reg  <= req.ip_address;
            mac_reg <= req.mac_address;
        end
        if (out_load)
        begin
            out_hit_reg    <= res_hit_reg;
            out_mac_reg    <= res_mac_reg;
            out_stored_reg <= res_stored_reg;
        end
    end

    // A write-back never targets the entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("table read and write collide on one entry");

    // An accepted request always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == ST_SCAN || state_reg == ST_DONE)
        else $error("accepted request did not start");

    // Stored flag only ever set by an insert, hit only by a lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && res_stored_reg |-> cmd_reg == CMD_INSERT)
        else $error("stored flag set by a non-insert");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && res_hit_reg |-> cmd_reg == CMD_LOOKUP)
        else $error("hit flag set by a non-lookup");

    // Read data only arrives during a table walk
    assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg |-> $past(state_reg) == ST_SCAN)
        else $error("read data outside a table walk");

endmodule

`default_nettype wire
